// ===== sv/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
// Depends on nothing; imported by the list cell and by the top level.
package ple_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int MAX_CAPACITY     = 64;
   localparam int DATA_W           = 32;
   localparam int POS_W            = 7;

   typedef enum logic [2:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_END   = 3'd1,
      OP_INS_POS   = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_END   = 3'd4,
      OP_DEL_POS   = 3'd5,
      OP_LIST      = 3'd6,
      OP_NONE      = 3'd7
   } ple_op_type;

   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_DELETED  = 3'd1,
      ST_LISTED   = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_BADPOS   = 3'd4,
      ST_FULL     = 3'd5
   } ple_status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } ple_cell_op_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_LIST
   } ple_fsm_type;

   typedef struct packed {
      ple_op_type               op;
      logic signed [DATA_W-1:0] value;
      logic        [POS_W-1:0]  position;
   } ple_req_type;

   typedef struct packed {
      ple_status_type           status;
      logic signed [DATA_W-1:0] data;
      logic                     last;
   } ple_rsp_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      ple_cell_op_type         kind;
      logic [POS_W-1:0]        slot;
      logic [POS_W-1:0]        count;
   } ple_cell_cmd_type;

endpackage

// ===== sv/ple_cell.sv =====
// One cell of the list chain: holds the entry at slot INDEX.
// Depends on ple_pkg for the broadcast command type.
module ple_cell
   import ple_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic                     clock,
   input  ple_cell_cmd_type         cmd,
   input  logic signed [DATA_W-1:0] left_data,
   input  logic signed [DATA_W-1:0] right_data,
   input  logic signed [DATA_W-1:0] new_data,
   output logic signed [DATA_W-1:0] data_ff
);

   localparam logic [POS_W-1:0] MY_SLOT = POS_W'(INDEX);

   logic signed [DATA_W-1:0] data_in;
   logic        [POS_W-1:0]  tail_slot;

   assign tail_slot = cmd.count - POS_W'(1);

   always_comb begin
      data_in = data_ff;
      case (cmd.kind)
         CELL_INSERT: begin
            if (MY_SLOT == cmd.slot) begin
               data_in = new_data;
            end else if (MY_SLOT > cmd.slot) begin
               data_in = left_data;
            end
         end
         CELL_DELETE: begin
            if (MY_SLOT >= cmd.slot) begin
               data_in = right_data;
            end
         end
         CELL_ROTATE: begin
            // wrap the front entry to the tail, pull the rest one slot forward
            if (MY_SLOT == tail_slot) begin
               data_in = new_data;
            end else if (MY_SLOT < tail_slot) begin
               data_in = right_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ===== sv/positional_list_engine.sv =====
// Top level of the positional list engine: control FSM, output register
// and the chain of ple_cell instances. Depends on ple_pkg and ple_cell.
//
//  channel | ports                           | direction | payload
//  req     | req_valid, req_stall, req_item  | in        | ple_req_type
//  rsp     | rsp_valid, rsp_stall, rsp_item  | out       | ple_rsp_type
//
// Inserts, deletes and error cases complete in the accepting cycle: the whole
// chain shifts then and the result goes to the output register.
// A listing starts its walk in the accepting cycle; then each step emits the
// front cell and rotates the occupied part of the chain by one until count
// entries are out, and no item is accepted meanwhile.
// Reset empties the list (count to zero); cell contents are not cleared.
// A stalled result holds the output register and so holds the list walk.
module positional_list_engine
   import ple_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ple_req_type req_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ple_rsp_type rsp_item
);

   localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   ple_fsm_type      state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ple_rsp_type      rsp_ff, rsp_in;

   ple_cell_cmd_type         cell_cmd;
   logic signed [DATA_W-1:0] new_data;
   logic signed [DATA_W-1:0] cell_data [CAPACITY];

   logic              out_free;
   logic              accept;
   logic              full;
   logic              empty;
   logic [POS_W:0]    count_ext;
   logic [POS_W:0]    pos_ext;
   logic              ins_pos_ok;
   logic              del_pos_ok;
   logic [SLOT_W-1:0] del_slot;
   logic [POS_W-1:0]  del_slot_wide;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == FSM_IDLE && out_free);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign empty      = (count_ff == '0);
   assign count_ext  = (POS_W+1)'(count_ff);
   assign pos_ext    = (POS_W+1)'(req_item.position);
   assign ins_pos_ok = (req_item.position != '0) && (pos_ext <= count_ext + (POS_W+1)'(1));
   assign del_pos_ok = (req_item.position != '0) && (pos_ext <= count_ext);

   always_comb begin
      case (req_item.op)
         OP_DEL_FRONT: del_slot_wide = '0;
         OP_DEL_END:   del_slot_wide = POS_W'(count_ff) - POS_W'(1);
         default:      del_slot_wide = req_item.position - POS_W'(1);
      endcase
   end
   assign del_slot = del_slot_wide[SLOT_W-1:0];

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      remain_in       = remain_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      cell_cmd.kind   = CELL_HOLD;
      cell_cmd.slot   = '0;
      cell_cmd.count  = POS_W'(count_ff);
      new_data        = req_item.value;

      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               case (req_item.op)
                  OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_in = '{status: ST_FULL, data: '0, last: 1'b1};
                     end else if (req_item.op == OP_INS_POS && !ins_pos_ok) begin
                        rsp_in = '{status: ST_BADPOS, data: '0, last: 1'b1};
                     end else begin
                        cell_cmd.kind = CELL_INSERT;
                        case (req_item.op)
                           OP_INS_FRONT: cell_cmd.slot = '0;
                           OP_INS_END:   cell_cmd.slot = POS_W'(count_ff);
                           default:      cell_cmd.slot = req_item.position - POS_W'(1);
                        endcase
                        count_in = count_ff + CNT_W'(1);
                        rsp_in   = '{status: ST_INSERTED, data: req_item.value, last: 1'b1};
                     end
                  end
                  OP_DEL_FRONT, OP_DEL_END, OP_DEL_POS: begin
                     rsp_valid_in = 1'b1;
                     if (empty) begin
                        rsp_in = '{status: ST_EMPTY, data: '0, last: 1'b1};
                     end else if (req_item.op == OP_DEL_POS && !del_pos_ok) begin
                        rsp_in = '{status: ST_BADPOS, data: '0, last: 1'b1};
                     end else begin
                        cell_cmd.kind = CELL_DELETE;
                        cell_cmd.slot = del_slot_wide;
                        count_in      = count_ff - CNT_W'(1);
                        rsp_in = '{status: ST_DELETED, data: cell_data[del_slot], last: 1'b1};
                     end
                  end
                  OP_LIST: begin
                     if (empty) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{status: ST_EMPTY, data: '0, last: 1'b1};
                     end else begin
                        state_in  = FSM_LIST;
                        remain_in = count_ff;
                     end
                  end
                  default: begin
                     // unused op code: drop the item
                  end
               endcase
            end
         end
         FSM_LIST: begin
            if (out_free) begin
               cell_cmd.kind = CELL_ROTATE;
               new_data      = cell_data[0];
               rsp_valid_in  = 1'b1;
               rsp_in = '{status: ST_LISTED, data: cell_data[0],
                          last: (remain_ff == CNT_W'(1))};
               remain_in = remain_ff - CNT_W'(1);
               if (remain_ff == CNT_W'(1)) begin
                  state_in = FSM_IDLE;
               end
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_data;
      logic signed [DATA_W-1:0] right_data;
      if (i == 0) begin : g_first
         assign left_data = new_data;
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_data = cell_data[i];
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end
      ple_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .new_data   (new_data),
         .data_ff    (cell_data[i])
      );
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_list_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_LIST |-> remain_ff != '0 && remain_ff <= count_ff)
      else $error("list walk counter out of range");

   a_list_start: assert property (@(posedge clock) disable iff (reset)
      accept && req_item.op == OP_LIST && !empty |=> state_ff == FSM_LIST)
      else $error("list walk did not start");

   a_list_count_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_LIST |=> $stable(count_ff))
      else $error("entry count changed during list walk");

endmodule

// ===== dv/positional_list_engine_tb.sv =====
// Self-checking testbench for positional_list_engine: directed and random list commands,
// a shadow list that predicts every result, and random idling on both channels.
// Depends on ple_pkg and the positional_list_engine RTL.
module positional_list_engine_tb
   import ple_pkg::*;
;

   localparam int LIST_CAP     = DEFAULT_CAPACITY;
   localparam int RANDOM_ITEMS = 95;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int LONG_HOLD    = 80;

   typedef struct {
      ple_req_type cmd;
      bit          wait_idle;   // hold this item until every result is back
   } backlog_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   ple_req_type req_item = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   ple_rsp_type rsp_item;

   backlog_entry_type        cmd_backlog[$];
   ple_rsp_type              due_results[$];
   logic signed [DATA_W-1:0] shadow_list[$];

   int  gen_count;      // list length as seen while building the stimulus
   int  scheduled;
   int  total_cmds;
   int  issued;
   int  accepted;
   int  rsp_seen;
   int  mismatches;
   int  cycles;
   int  hold_left;
   bit  hold_done;
   bit  req_fire;

   positional_list_engine #(.CAPACITY(LIST_CAP)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
   end

   function automatic void log_mismatch(string what);
      if (mismatches < 10) begin
         $display("ERROR @%0d: %s", cycles, what);
      end
      mismatches++;
   endfunction

   function automatic void owe_result(ple_status_type status, logic signed [DATA_W-1:0] data,
                                      logic last);
      ple_rsp_type r;
      r.status = status;
      r.data   = data;
      r.last   = last;
      due_results.push_back(r);
   endfunction

   // Apply one command to the shadow list and queue the results it causes.
   function automatic void predict_list_op(ple_req_type cmd);
      int                       pos;
      int                       len;
      logic signed [DATA_W-1:0] v;
      pos = cmd.position;
      len = shadow_list.size();
      v   = cmd.value;
      case (cmd.op)
         OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
            if (len >= LIST_CAP) begin
               owe_result(ST_FULL, '0, 1'b1);
            end else if (cmd.op == OP_INS_POS && (pos == 0 || pos > len + 1)) begin
               owe_result(ST_BADPOS, '0, 1'b1);
            end else begin
               if (cmd.op == OP_INS_FRONT) shadow_list.push_front(v);
               else if (cmd.op == OP_INS_END) shadow_list.push_back(v);
               else shadow_list.insert(pos - 1, v);
               owe_result(ST_INSERTED, v, 1'b1);
            end
         end
         OP_DEL_FRONT, OP_DEL_END, OP_DEL_POS: begin
            if (len == 0) begin
               owe_result(ST_EMPTY, '0, 1'b1);
            end else if (cmd.op == OP_DEL_POS && (pos == 0 || pos > len)) begin
               owe_result(ST_BADPOS, '0, 1'b1);
            end else begin
               if (cmd.op == OP_DEL_FRONT) begin
                  v = shadow_list.pop_front();
               end else if (cmd.op == OP_DEL_END) begin
                  v = shadow_list.pop_back();
               end else begin
                  v = shadow_list[pos - 1];
                  shadow_list.delete(pos - 1);
               end
               owe_result(ST_DELETED, v, 1'b1);
            end
         end
         OP_LIST: begin
            if (len == 0) begin
               owe_result(ST_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < len; i++) begin
                  owe_result(ST_LISTED, shadow_list[i], i == len - 1);
               end
            end
         end
         default: ;
      endcase
   endfunction

   // Append a command to the backlog, tracking the list length it leaves behind.
   task automatic queue_cmd(ple_op_type op, logic signed [DATA_W-1:0] value, int pos,
                            bit wait_idle = 1'b0);
      backlog_entry_type e;
      e.cmd.op       = op;
      e.cmd.value    = value;
      e.cmd.position = pos[POS_W-1:0];
      e.wait_idle    = wait_idle;
      cmd_backlog.push_back(e);
      total_cmds++;
      if (op != OP_NONE) scheduled++;
      case (op)
         OP_INS_FRONT, OP_INS_END: if (gen_count < LIST_CAP) gen_count++;
         OP_INS_POS:
            if (gen_count < LIST_CAP && pos >= 1 && pos <= gen_count + 1) gen_count++;
         OP_DEL_FRONT, OP_DEL_END: if (gen_count > 0) gen_count--;
         OP_DEL_POS: if (gen_count > 0 && pos >= 1 && pos <= gen_count) gen_count--;
         default: ;
      endcase
   endtask

   function automatic bit sender_rests();
      if (issued >= 50 && issued < 90) return 1'b0;
      return $urandom_range(99) < 36;
   endfunction

   // Driver: present the next item once the current one has been taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (cmd_backlog.size() != 0 &&
             !(cmd_backlog[0].wait_idle && due_results.size() != 0) &&
             !sender_rests()) begin
            req_item  <= cmd_backlog[0].cmd;
            req_valid <= 1'b1;
            cmd_backlog.pop_front();
            issued    <= issued + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, one long hold-off, and a calm stretch.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && rsp_seen >= 40) begin
         rsp_stall <= 1'b1;
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end else if (rsp_seen >= 100 && rsp_seen < 180) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= $urandom_range(99) < 36;
      end
   end

   // Monitor: predict on every accepted item, then check every accepted result.
   always @(posedge clock) begin
      ple_rsp_type want;
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         predict_list_op(req_item);
         accepted <= accepted + 1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen <= rsp_seen + 1;
         if (due_results.size() == 0) begin
            log_mismatch($sformatf("unexpected result status=%0d data=%0d last=%0b",
                                   rsp_item.status, rsp_item.data, rsp_item.last));
         end else begin
            want = due_results.pop_front();
            if (rsp_item.status !== want.status || rsp_item.data !== want.data ||
                rsp_item.last !== want.last) begin
               log_mismatch($sformatf(
                  "expected status=%0d data=%0d last=%0b, got status=%0d data=%0d last=%0b",
                  want.status, want.data, want.last,
                  rsp_item.status, rsp_item.data, rsp_item.last));
            end
         end
      end
   end

   initial begin
      int pick;
      bit first;

      // Directed: empty-list errors, bad positions, value extremes, full walk-down.
      queue_cmd(OP_LIST, '0, 0);
      queue_cmd(OP_DEL_FRONT, '0, 1);
      queue_cmd(OP_DEL_END, '0, 1);
      queue_cmd(OP_DEL_POS, '0, 0);
      queue_cmd(OP_INS_POS, 32'sd7, 0);
      queue_cmd(OP_INS_POS, 32'sd9, 2);
      queue_cmd(OP_INS_FRONT, 32'sh8000_0000, 0);
      queue_cmd(OP_INS_END, 32'sh7FFF_FFFF, 0);
      queue_cmd(OP_INS_POS, -32'sd1, 2);
      queue_cmd(OP_INS_POS, 32'sd0, 1);
      queue_cmd(OP_INS_POS, 32'sh5555_5555, 5);
      queue_cmd(OP_INS_POS, 32'shAAAA_AAAA, 127);
      queue_cmd(OP_LIST, '0, 0);
      queue_cmd(OP_DEL_POS, '0, 0);
      queue_cmd(OP_DEL_POS, '0, 6);
      queue_cmd(OP_DEL_POS, '0, 3);
      queue_cmd(OP_DEL_FRONT, '0, 0);
      queue_cmd(OP_DEL_END, '0, 0);
      queue_cmd(OP_NONE, -32'sd1, 127);
      queue_cmd(OP_LIST, '0, 0);
      queue_cmd(OP_DEL_POS, '0, 2);
      queue_cmd(OP_DEL_POS, '0, 1);
      queue_cmd(OP_LIST, '0, 0);

      // Random: mostly legal commands, with fill-to-full and drain-to-empty bursts.
      scheduled = 0;
      first = 1'b1;
      while (scheduled < RANDOM_ITEMS) begin
         pick = first ? 0 : $urandom_range(99);
         if (pick < 12) begin
            while (gen_count < LIST_CAP) begin
               queue_cmd(ple_op_type'($urandom_range(0, 2)), $urandom,
                         $urandom_range(1, gen_count + 1), first);
               first = 1'b0;
            end
            repeat ($urandom_range(1, 2)) begin
               queue_cmd(ple_op_type'($urandom_range(0, 2)), $urandom, $urandom_range(0, 127));
            end
            queue_cmd(OP_LIST, $urandom, $urandom_range(0, 127));
         end else if (pick < 20) begin
            while (gen_count > 0) begin
               queue_cmd(ple_op_type'($urandom_range(3, 5)), $urandom,
                         $urandom_range(1, gen_count));
            end
            queue_cmd(ple_op_type'($urandom_range(3, 5)), $urandom, $urandom_range(0, 127));
         end else if (pick < 50) begin
            queue_cmd(ple_op_type'($urandom_range(0, 2)), $urandom,
                      $urandom_range(1, gen_count + 1));
         end else if (pick < 75) begin
            queue_cmd(ple_op_type'($urandom_range(3, 5)), $urandom,
                      $urandom_range(1, gen_count > 0 ? gen_count : 1));
         end else if (pick < 87) begin
            queue_cmd(OP_LIST, $urandom, $urandom_range(0, 127));
         end else if (pick < 95) begin
            queue_cmd($urandom_range(1) ? OP_INS_POS : OP_DEL_POS, $urandom,
                      $urandom_range(0, 127));
         end else begin
            queue_cmd(OP_NONE, $urandom, $urandom_range(0, 127));
         end
         // Around the middle of the run, wait for every result to come back, then list the whole list.
         if (scheduled >= 60 && scheduled < 62) begin
            queue_cmd(OP_LIST, $urandom, $urandom_range(0, 127), 1'b1);
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted != total_cmds || due_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results still due", cycles, due_results.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/ple_pkg.sv
sv/ple_cell.sv
sv/positional_list_engine.sv
dv/positional_list_engine_tb.sv
